>>> rtl/stepper_ramp_pulse_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Stepper ramp pulse sequencer - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef STEPPER_RAMP_PULSE_SEQUENCER_DEFINES_SVH
`define STEPPER_RAMP_PULSE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRPS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRPS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/srps_pkg.sv
// ----------------------------------------------------------------------------
// srps_pkg
// Shared codes and types of the stepper ramp pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package srps_pkg;

  localparam int PROFILE_COUNT = 4;

  // Request operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_RAMP_LEN_0   = 3'd0;
  localparam logic [2:0] CFG_RAMP_LEN_1   = 3'd1;
  localparam logic [2:0] CFG_RAMP_LEN_2   = 3'd2;
  localparam logic [2:0] CFG_RAMP_LEN_3   = 3'd3;
  localparam logic [2:0] CFG_FIXED_DELAY  = 3'd4;
  localparam logic [2:0] CFG_SYSTEM_READY = 3'd5;
  localparam logic [2:0] CFG_DEBUG_MODE   = 3'd6;

  localparam logic [1:0] FALLBACK_PROFILE = 2'd3;
  localparam logic [15:0] FIXED_DELAY_RESET = 16'd500;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_START,
    KIND_WRITE,
    KIND_NOP
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_UP,
    PH_CRUISE,
    PH_DOWN
  } phase_t;

  // What the executor does with one request
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_DEC,
    ACT_LOW,
    ACT_RAMP_NEXT,
    ACT_RAMP_HOLD,
    ACT_RAMP_LAST,
    ACT_RAMP_PREV,
    ACT_REPEAT,
    ACT_FINISH,
    ACT_START_RAMP,
    ACT_START_FIXED,
    ACT_REJECT,
    ACT_WRITE
  } act_t;

  // Classified request as it travels from front to back
  typedef struct packed {
    kind_t       kind;
    logic        motor;
    logic [1:0]  profile;   // chosen profile for start, target profile for write
    logic        ramped;
    logic        go;        // start with a nonzero pulse count
    logic [15:0] count;     // initial cruise count
    logic [15:0] delay0;    // fixed half-period for unramped moves
    logic        wr_en;     // write index inside the table
    logic [8:0]  wr_index;
    logic [15:0] wr_value;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/srps_front.sv
// ----------------------------------------------------------------------------
// srps_front
// Configuration registers and request classification.
// ----------------------------------------------------------------------------
`default_nettype none

module srps_front #(
  parameter int RAMP_DEPTH = 512,
  localparam int LEN_W = $clog2(RAMP_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic [1:0]        operation,
  input  wire logic              motor_side,
  input  wire logic              left_tight,
  input  wire logic              right_tight,
  input  wire logic [15:0]       pulse_count,
  input  wire logic [1:0]        table_profile,
  input  wire logic [8:0]        table_index,
  input  wire logic [15:0]       table_value,
  output srps_pkg::cmd_t         cmd,
  output logic [LEN_W-1:0]       cmd_len
);
  import srps_pkg::*;

  logic [9:0]  ramp_len [PROFILE_COUNT];
  logic [15:0] fixed_delay;
  logic        system_ready;
  logic        debug_mode;

  logic [1:0]  prof;
  logic [16:0] len_raw;
  logic [16:0] len_sat;
  logic [16:0] len_x2;
  logic        ramped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROFILE_COUNT; i++) begin
        ramp_len[i] <= '0;
      end
      fixed_delay  <= FIXED_DELAY_RESET;
      system_ready <= 1'b0;
      debug_mode   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RAMP_LEN_0:   ramp_len[0]  <= cfg_data[9:0];
        CFG_RAMP_LEN_1:   ramp_len[1]  <= cfg_data[9:0];
        CFG_RAMP_LEN_2:   ramp_len[2]  <= cfg_data[9:0];
        CFG_RAMP_LEN_3:   ramp_len[3]  <= cfg_data[9:0];
        CFG_FIXED_DELAY:  fixed_delay  <= cfg_data;
        CFG_SYSTEM_READY: system_ready <= cfg_data[0];
        CFG_DEBUG_MODE:   debug_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Profile from motor side and grip flags
  always_comb begin
    if (!system_ready) begin
      prof = FALLBACK_PROFILE;
    end else if (motor_side) begin
      prof = right_tight ? (left_tight ? 2'd2 : 2'd1) : 2'd0;
    end else begin
      prof = left_tight ? (right_tight ? 2'd2 : 2'd1) : 2'd0;
    end
  end

  // Clamp the ramp length to the table depth
  assign len_raw = {7'd0, ramp_len[prof]};
  assign len_sat = (len_raw > 17'(RAMP_DEPTH)) ? 17'(RAMP_DEPTH) : len_raw;
  assign len_x2  = {len_sat[15:0], 1'b0};
  assign ramped  = system_ready && !debug_mode && (len_sat != '0) &&
                   ({1'b0, pulse_count} >= len_x2);

  always_comb begin
    unique case (operation)
      OP_TICK:  cmd.kind = KIND_TICK;
      OP_START: cmd.kind = KIND_START;
      OP_WRITE: cmd.kind = KIND_WRITE;
      default:  cmd.kind = KIND_NOP;
    endcase
    cmd.motor    = motor_side;
    cmd.profile  = (operation == OP_WRITE) ? table_profile : prof;
    cmd.ramped   = ramped;
    cmd.go       = (pulse_count != 16'd0);
    cmd.count    = ramped ? (pulse_count - len_x2[15:0]) : (pulse_count - 16'd1);
    cmd.delay0   = fixed_delay;
    cmd.wr_en    = ({23'd0, table_index} < 32'(RAMP_DEPTH));
    cmd.wr_index = table_index;
    cmd.wr_value = table_value;
  end

  assign cmd_len = LEN_W'(len_sat);

endmodule

`default_nettype wire

>>> rtl/srps_queue.sv
// ----------------------------------------------------------------------------
// srps_queue
// Two-entry request queue between the front and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module srps_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic              valid,
  output logic [W-1:0]      dout
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/srps_back.sv
// ----------------------------------------------------------------------------
// srps_back
// Move executor: delay table, pulse sequencing and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srps_back #(
  parameter int RAMP_DEPTH = 512,
  localparam int LEN_W = $clog2(RAMP_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire srps_pkg::cmd_t   cmd,
  input  wire logic [LEN_W-1:0] cmd_len,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  step_level,
  output logic                  step_motor,
  output logic                  busy_res,
  output logic                  move_done,
  output logic                  start_rejected
);
  import srps_pkg::*;

  localparam int IDX_W       = $clog2(RAMP_DEPTH);
  localparam int TABLE_DEPTH = PROFILE_COUNT * RAMP_DEPTH;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  logic [15:0] table_mem [TABLE_DEPTH];
  logic [15:0] rdata;

  phase_t           phase, phase_next;
  act_t             act;
  logic [IDX_W-1:0] pos, pos_next;
  logic [LEN_W-1:0] move_len, len_next;
  logic [15:0]      cruise, cruise_next;
  logic [15:0]      cnt, cnt_next;
  logic [15:0]      cur, cur_next;
  logic             half, half_next;
  logic             ld_pend, ld_next;
  logic [1:0]       prof, prof_next;
  logic             motor, motor_next;

  logic [15:0]      eff_cur;
  logic [15:0]      eff_cnt;
  logic [LEN_W:0]   pos_inc;
  logic             fire;
  logic             rd_en;
  logic [IDX_W-1:0] rd_pos;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic             we;
  logic             done;
  logic             rej;

  assign fire  = q_valid && (!out_valid || !out_stall);
  assign q_pop = fire;

  // A freshly fetched entry lands in the cycle after its request
  assign eff_cur = ld_pend ? rdata : cur;
  assign eff_cnt = ld_pend ? ((rdata == 16'd0) ? 16'd1 : rdata) : cnt;
  assign pos_inc = (LEN_W + 1)'(pos) + (LEN_W + 1)'(1);

  // Next state
  always_comb begin
    phase_next = phase;
    act        = ACT_NONE;
    if (fire) begin
      case (cmd.kind)
        KIND_TICK: begin
          if (phase != PH_IDLE) begin
            if (eff_cnt > 16'd1) begin
              act = ACT_DEC;
            end else if (half) begin
              act = ACT_LOW;
            end else begin
              unique case (phase)
                PH_UP: begin
                  if (pos_inc < (LEN_W + 1)'(move_len)) begin
                    act = ACT_RAMP_NEXT;
                  end else if (cruise != 16'd0) begin
                    act        = ACT_REPEAT;
                    phase_next = PH_CRUISE;
                  end else begin
                    act        = ACT_RAMP_HOLD;
                    phase_next = PH_DOWN;
                  end
                end
                PH_CRUISE: begin
                  if (cruise != 16'd0) begin
                    act = ACT_REPEAT;
                  end else if (move_len != '0) begin
                    act        = ACT_RAMP_LAST;
                    phase_next = PH_DOWN;
                  end else begin
                    act        = ACT_FINISH;
                    phase_next = PH_IDLE;
                  end
                end
                PH_DOWN: begin
                  if (pos != '0) begin
                    act = ACT_RAMP_PREV;
                  end else begin
                    act        = ACT_FINISH;
                    phase_next = PH_IDLE;
                  end
                end
                default: act = ACT_NONE;
              endcase
            end
          end
        end
        KIND_START: begin
          if (phase != PH_IDLE) begin
            act = ACT_REJECT;
          end else if (cmd.go) begin
            if (cmd.ramped) begin
              act        = ACT_START_RAMP;
              phase_next = PH_UP;
            end else begin
              act        = ACT_START_FIXED;
              phase_next = PH_CRUISE;
            end
          end
        end
        KIND_WRITE: begin
          if (cmd.wr_en) begin
            act = ACT_WRITE;
          end
        end
        default: act = ACT_NONE;
      endcase
    end
  end

  // Datapath and outputs per action
  always_comb begin
    cur_next    = eff_cur;
    cnt_next    = eff_cnt;
    ld_next     = 1'b0;
    half_next   = half;
    pos_next    = pos;
    cruise_next = cruise;
    len_next    = move_len;
    prof_next   = prof;
    motor_next  = motor;
    rd_en       = 1'b0;
    rd_pos      = pos;
    done        = 1'b0;
    rej         = 1'b0;
    we          = 1'b0;
    unique case (act)
      ACT_NONE: ;
      ACT_DEC: cnt_next = eff_cnt - 16'd1;
      ACT_LOW: begin
        half_next = 1'b0;
        cnt_next  = (eff_cur == 16'd0) ? 16'd1 : eff_cur;
      end
      ACT_RAMP_NEXT: begin
        pos_next  = pos + IDX_W'(1);
        rd_pos    = pos + IDX_W'(1);
        rd_en     = 1'b1;
        ld_next   = 1'b1;
        half_next = 1'b1;
      end
      ACT_RAMP_HOLD: begin
        rd_en     = 1'b1;
        ld_next   = 1'b1;
        half_next = 1'b1;
      end
      ACT_RAMP_LAST: begin
        pos_next  = IDX_W'(move_len - LEN_W'(1));
        rd_pos    = IDX_W'(move_len - LEN_W'(1));
        rd_en     = 1'b1;
        ld_next   = 1'b1;
        half_next = 1'b1;
      end
      ACT_RAMP_PREV: begin
        pos_next  = pos - IDX_W'(1);
        rd_pos    = pos - IDX_W'(1);
        rd_en     = 1'b1;
        ld_next   = 1'b1;
        half_next = 1'b1;
      end
      ACT_REPEAT: begin
        cruise_next = cruise - 16'd1;
        cnt_next    = (eff_cur == 16'd0) ? 16'd1 : eff_cur;
        half_next   = 1'b1;
      end
      ACT_FINISH: begin
        cnt_next  = 16'd0;
        half_next = 1'b0;
        done      = 1'b1;
      end
      ACT_START_RAMP: begin
        prof_next   = cmd.profile;
        motor_next  = cmd.motor;
        pos_next    = '0;
        rd_pos      = '0;
        len_next    = cmd_len;
        cruise_next = cmd.count;
        rd_en       = 1'b1;
        ld_next     = 1'b1;
        half_next   = 1'b1;
      end
      ACT_START_FIXED: begin
        prof_next   = cmd.profile;
        motor_next  = cmd.motor;
        pos_next    = '0;
        len_next    = '0;
        cruise_next = cmd.count;
        cur_next    = cmd.delay0;
        cnt_next    = (cmd.delay0 == 16'd0) ? 16'd1 : cmd.delay0;
        half_next   = 1'b1;
      end
      ACT_REJECT: rej = 1'b1;
      ACT_WRITE:  we  = 1'b1;
      default: ;
    endcase
  end

  assign rd_addr = ADDR_W'(32'(prof_next) * 32'(RAMP_DEPTH) + 32'(rd_pos));
  assign wr_addr = ADDR_W'(32'(cmd.profile) * 32'(RAMP_DEPTH) + 32'(cmd.wr_index));

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[wr_addr] <= cmd.wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      pos      <= '0;
      move_len <= '0;
      cruise   <= '0;
      cnt      <= '0;
      cur      <= '0;
      half     <= 1'b0;
      ld_pend  <= 1'b0;
      prof     <= '0;
      motor    <= 1'b0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      move_len <= len_next;
      cruise   <= cruise_next;
      cnt      <= cnt_next;
      cur      <= cur_next;
      half     <= half_next;
      ld_pend  <= ld_next;
      prof     <= prof_next;
      motor    <= motor_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      step_level     <= half_next;
      step_motor     <= motor_next;
      busy_res       <= (phase_next != PH_IDLE);
      move_done      <= done;
      start_rejected <= rej;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stepper_ramp_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_sequencer
// Ramped step-pulse generator for one pulse line shared by two motors.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the queue has room: a
// microsecond tick, a move start or a delay table write, and answers every
// request with one status result (step level, motor, busy, move done, start
// rejected), held while the result side stalls. The front holds the cfg
// registers and classifies requests, a two-entry queue sits between it and
// the executor, and the executor owns the delay table and a result register,
// so a stalled result does not stop intake until the queue is full.
// Sustained rate is one request per clock unless the result side stalls; it
// is set by the executor, which retires one request per cycle with a single
// table read port whose registered data is folded into the delay counters on
// the following clock. The delay table needs no clearing pass after reset:
// table entries must be written before a move reads them. Configuration is
// to be written through the cfg port while no move is running; not enforced.
`default_nettype none
`include "stepper_ramp_pulse_sequencer_defines.svh"

module stepper_ramp_pulse_sequencer #(
  parameter int RAMP_DEPTH = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic        motor_side,
  input  wire logic        left_tight,
  input  wire logic        right_tight,
  input  wire logic [15:0] pulse_count,
  input  wire logic [1:0]  table_profile,
  input  wire logic [8:0]  table_index,
  input  wire logic [15:0] table_value,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             step_level,
  output logic             step_motor,
  output logic             busy_res,
  output logic             move_done,
  output logic             start_rejected,
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import srps_pkg::*;

  localparam int LEN_W = $clog2(RAMP_DEPTH + 1);
  localparam int QW    = $bits(cmd_t) + LEN_W;

  cmd_t             f_cmd;
  logic [LEN_W-1:0] f_len;
  cmd_t             q_cmd;
  logic [LEN_W-1:0] q_len;
  logic [QW-1:0]    q_dout;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             push;

  // Accept a request whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  srps_front #(
    .RAMP_DEPTH (RAMP_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .motor_side    (motor_side),
    .left_tight    (left_tight),
    .right_tight   (right_tight),
    .pulse_count   (pulse_count),
    .table_profile (table_profile),
    .table_index   (table_index),
    .table_value   (table_value),
    .cmd           (f_cmd),
    .cmd_len       (f_len)
  );

  // Hold classified requests until the executor can take them
  srps_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({f_cmd, f_len}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  assign q_cmd = q_dout[QW-1:LEN_W];
  assign q_len = q_dout[LEN_W-1:0];

  // Advance the move and drive the result register
  srps_back #(
    .RAMP_DEPTH (RAMP_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .cmd            (q_cmd),
    .cmd_len        (q_len),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .step_level     (step_level),
    .step_motor     (step_motor),
    .busy_res       (busy_res),
    .move_done      (move_done),
    .start_rejected (start_rejected)
  );

  // A finishing result leaves the line low and the sequencer idle
  `SRPS_ASSERT_IMP(a_done_idle, clk, rst, out_valid && move_done,
                   !busy_res && !step_level, "move_done while still busy or high")
  // A rejected start only happens during a move
  `SRPS_ASSERT_IMP(a_reject_busy, clk, rst, out_valid && start_rejected,
                   busy_res && !move_done, "start rejected while idle")
  // Intake stalls only with requests waiting in the queue
  `SRPS_ASSERT_IMP(a_stall_queued, clk, rst, in_stall, q_valid,
                   "input stalled with empty queue")
  // A queued request with a free result side is retired
  `SRPS_ASSERT_NXT(a_queue_drains, clk, rst, q_valid && !out_stall, out_valid,
                   "queued request not executed")

endmodule

`default_nettype wire

>>> tb/stepper_ramp_pulse_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_sequencer_tb
// Self-checking bench for the step-pulse sequencer. Requests wait in a backlog
// that the stimulus process fills phase by phase. A clocked driver sends them
// under random sender gaps, and a clocked monitor checks every status result
// against a cycle-free prediction of the pulse line.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_sequencer_tb;
  import srps_pkg::*;

  localparam int DEPTH = 512;
  localparam logic [1:0] OP_NOP = 2'd3;  // unassigned code, must change nothing
  localparam int GEN = 0;                // predictor copy that runs ahead with stimulus
  localparam int EXP = 1;                // predictor copy that follows accepted requests
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_REQS = 64;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        side;
    logic        lt;
    logic        rt;
    logic [15:0] n;
    logic [1:0]  tp;
    logic [8:0]  ti;
    logic [15:0] tv;
    logic        wait_drain;  // hold this request until every result is back
  } step_req_t;

  typedef struct packed {
    logic level;
    logic motor;
    logic busy;
    logic done;
    logic rejected;
  } step_status_t;

  typedef struct packed {
    phase_t      ph;
    logic [9:0]  ramp_pos;
    logic [15:0] cruise_left;
    logic [15:0] countdown;
    logic        high_half;
    logic [1:0]  profile;
    logic        motor;
    logic [9:0]  ramp_len;
    logic [15:0] half_period;
  } seq_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_TICK;
  logic        motor_side = 1'b0;
  logic        left_tight = 1'b0;
  logic        right_tight = 1'b0;
  logic [15:0] pulse_count = '0;
  logic [1:0]  table_profile = '0;
  logic [8:0]  table_index = '0;
  logic [15:0] table_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        step_level;
  logic        step_motor;
  logic        busy_res;
  logic        move_done;
  logic        start_rejected;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Register shadow, shared by both predictor copies: it only changes while idle
  logic [9:0]  ramp_len_q [4];
  logic [15:0] fixed_delay_q;
  logic        ready_q;
  logic        debug_q;

  seq_state_t  st [2];
  logic [15:0] delay_mem [2][PROFILE_COUNT * DEPTH];

  step_req_t    request_backlog [$];
  step_status_t status_due [$];
  step_req_t    next_req;
  step_req_t    seen_req;
  step_status_t want;
  idle_mode_t   idle_mode = IDLE_NONE;
  int           mismatch_count = 0;
  int           quiet_cycles = 0;

  stepper_ramp_pulse_sequencer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .motor_side(motor_side),
    .left_tight(left_tight),
    .right_tight(right_tight),
    .pulse_count(pulse_count),
    .table_profile(table_profile),
    .table_index(table_index),
    .table_value(table_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .step_level(step_level),
    .step_motor(step_motor),
    .busy_res(busy_res),
    .move_done(move_done),
    .start_rejected(start_rejected),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Pulse line prediction
  // ---------------------------------------------------------------------------

  // Read a delay entry of the profile that the running move latched.
  function automatic logic [15:0] ramp_entry(int c, logic [9:0] pos);
    return delay_mem[c][int'(st[c].profile) * DEPTH + int'(pos)];
  endfunction

  // Start the high half of a pulse; a zero half-period still lasts one tick.
  function automatic void load_half(int c, logic [15:0] d);
    st[c].half_period = d;
    st[c].countdown = (d == 16'd0) ? 16'd1 : d;
    st[c].high_half = 1'b1;
  endfunction

  // End of a low half: pick the next pulse's delay, or report that the move is over.
  function automatic bit advance_pulse(int c);
    case (st[c].ph)
      PH_UP: begin
        if (int'(st[c].ramp_pos) + 1 < int'(st[c].ramp_len)) begin
          st[c].ramp_pos = st[c].ramp_pos + 10'd1;
          load_half(c, ramp_entry(c, st[c].ramp_pos));
        end else if (st[c].cruise_left != 16'd0) begin
          // cruise repeats the last ramp delay
          st[c].cruise_left = st[c].cruise_left - 16'd1;
          st[c].ph = PH_CRUISE;
          load_half(c, st[c].half_period);
        end else begin
          st[c].ph = PH_DOWN;
          load_half(c, ramp_entry(c, st[c].ramp_pos));
        end
        return 1'b1;
      end
      PH_CRUISE: begin
        if (st[c].cruise_left != 16'd0) begin
          st[c].cruise_left = st[c].cruise_left - 16'd1;
          load_half(c, st[c].half_period);
          return 1'b1;
        end
        if (st[c].ramp_len != 10'd0) begin
          st[c].ph = PH_DOWN;
          st[c].ramp_pos = st[c].ramp_len - 10'd1;
          load_half(c, ramp_entry(c, st[c].ramp_pos));
          return 1'b1;
        end
      end
      PH_DOWN: begin
        if (st[c].ramp_pos != 10'd0) begin
          st[c].ramp_pos = st[c].ramp_pos - 10'd1;
          load_half(c, ramp_entry(c, st[c].ramp_pos));
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Apply one request to predictor copy c and return the status it must produce.
  function automatic step_status_t predict_status(int c, step_req_t r);
    logic [1:0]   prof;
    int           len;
    step_status_t s;
    s = '0;
    case (r.op)
      OP_TICK: begin
        if (st[c].ph != PH_IDLE) begin
          if (st[c].countdown > 16'd1) begin
            st[c].countdown = st[c].countdown - 16'd1;
          end else if (st[c].high_half) begin
            st[c].high_half = 1'b0;
            st[c].countdown = (st[c].half_period == 16'd0) ? 16'd1 : st[c].half_period;
          end else if (!advance_pulse(c)) begin
            st[c].ph = PH_IDLE;
            st[c].countdown = 16'd0;
            st[c].high_half = 1'b0;
            s.done = 1'b1;
          end
        end
      end
      OP_START: begin
        if (st[c].ph != PH_IDLE) begin
          s.rejected = 1'b1;
        end else if (r.n != 16'd0) begin
          // grip flags pick the profile: none, one side, both
          if (!ready_q) prof = FALLBACK_PROFILE;
          else if (r.side) prof = r.rt ? (r.lt ? 2'd2 : 2'd1) : 2'd0;
          else prof = r.lt ? (r.rt ? 2'd2 : 2'd1) : 2'd0;
          len = (int'(ramp_len_q[prof]) > DEPTH) ? DEPTH : int'(ramp_len_q[prof]);
          st[c].profile = prof;
          st[c].motor = r.side;
          st[c].ramp_pos = 10'd0;
          if (ready_q && !debug_q && len > 0 && int'(r.n) >= 2 * len) begin
            st[c].ramp_len = len[9:0];
            st[c].cruise_left = r.n - 16'(2 * len);
            st[c].ph = PH_UP;
            load_half(c, ramp_entry(c, 10'd0));
          end else begin
            st[c].ramp_len = 10'd0;
            st[c].cruise_left = r.n - 16'd1;
            st[c].ph = PH_CRUISE;
            load_half(c, fixed_delay_q);
          end
        end
      end
      OP_WRITE: delay_mem[c][int'(r.tp) * DEPTH + int'(r.ti)] = r.tv;
      default: ;
    endcase
    s.busy = (st[c].ph != PH_IDLE);
    s.level = s.busy & st[c].high_half;
    s.motor = st[c].motor;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building; runs the look-ahead copy so moves can be finished
  // ---------------------------------------------------------------------------

  function automatic step_req_t blank_req(logic [1:0] op);
    step_req_t r;
    r.op = op;
    r.side = 1'($urandom_range(1));
    r.lt = 1'($urandom_range(1));
    r.rt = 1'($urandom_range(1));
    r.n = 16'($urandom_range(65535));
    r.tp = 2'($urandom_range(3));
    r.ti = 9'($urandom_range(511));
    r.tv = 16'($urandom_range(65535, 1));
    r.wait_drain = 1'b0;
    return r;
  endfunction

  function automatic void queue_req(step_req_t r);
    void'(predict_status(GEN, r));
    request_backlog.push_back(r);
  endfunction

  function automatic void add_start(logic side, logic lt, logic rt, logic [15:0] n);
    step_req_t r;
    r = blank_req(OP_START);
    r.side = side;
    r.lt = lt;
    r.rt = rt;
    r.n = n;
    queue_req(r);
  endfunction

  function automatic void add_write(logic [1:0] tp, logic [8:0] ti, logic [15:0] tv);
    step_req_t r;
    r = blank_req(OP_WRITE);
    r.tp = tp;
    r.ti = ti;
    r.tv = tv;
    queue_req(r);
  endfunction

  // Tick until the look-ahead copy says the move is over.
  function automatic void finish_move();
    while (st[GEN].ph != PH_IDLE) queue_req(blank_req(OP_TICK));
  endfunction

  // One random request; returns 1 when it does something the block must act on.
  function automatic int add_random_req(bit hold);
    step_req_t r;
    step_req_t big;
    int        pick;
    bit        busy;
    int        counts;
    busy = (st[GEN].ph != PH_IDLE);
    pick = $urandom_range(99);
    r = blank_req(OP_TICK);
    r.wait_drain = hold || ($urandom_range(99) < 2);
    counts = 1;
    if (busy) begin
      if (pick < 84) r.op = OP_TICK;
      else if (pick < 92) r.op = OP_WRITE;
      else if (pick < 97) r.op = OP_START;  // rejected; full-range count
      else begin
        r.op = OP_NOP;
        counts = 0;
      end
    end else begin
      if (pick < 55) begin
        r.op = OP_START;
        r.n = 16'($urandom_range(20, 1));
      end else if (pick < 75) begin
        r.op = OP_WRITE;
      end else begin
        counts = 0;
        if (pick < 88) r.op = OP_TICK;
        else if (pick < 95) begin
          r.op = OP_START;
          r.n = 16'd0;
        end else r.op = OP_NOP;
      end
    end
    if (r.op == OP_WRITE) begin
      // Keep table delays short; a wide value is overwritten before any tick reads it.
      if ($urandom_range(3) == 0) begin
        big = r;
        queue_req(big);
        r.wait_drain = 1'b0;
      end
      r.tv = 16'($urandom_range(3, 1));
    end
    queue_req(r);
    return counts;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 64;
      IDLE_BOTH: return $urandom_range(99) < 23;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 64;
      IDLE_BOTH: return $urandom_range(99) < 23;
      default:   return 1'b0;
    endcase
  endfunction

  // A draining request waits for an empty channel; anything in flight this edge
  // counts as busy so the decision does not hinge on process order.
  function automatic bit drain_hold();
    return request_backlog[0].wait_drain &&
           (in_valid || status_due.size() != 0 || (out_valid && !out_stall));
  endfunction

  // Drive: present the next request once the previous one is taken; hold while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (request_backlog.size() != 0 && !sender_gap() && !drain_hold()) begin
        next_req = request_backlog.pop_front();
        in_valid      <= 1'b1;
        operation     <= next_req.op;
        motor_side    <= next_req.side;
        left_tight    <= next_req.lt;
        right_tight   <= next_req.rt;
        pulse_count   <= next_req.n;
        table_profile <= next_req.tp;
        table_index   <= next_req.ti;
        table_value   <= next_req.tv;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= receiver_stall();
  end

  function automatic void check_field(string name, logic exp_bit, logic got_bit);
    if (got_bit !== exp_bit) begin
      $error("%s: expected %0b, got %0b", name, exp_bit, got_bit);
      mismatch_count++;
    end
  endfunction

  // Predict on every taken request, compare every taken result with the oldest one.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen_req.op = operation;
        seen_req.side = motor_side;
        seen_req.lt = left_tight;
        seen_req.rt = right_tight;
        seen_req.n = pulse_count;
        seen_req.tp = table_profile;
        seen_req.ti = table_index;
        seen_req.tv = table_value;
        seen_req.wait_drain = 1'b0;
        status_due.push_back(predict_status(EXP, seen_req));
      end
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("status result with no request outstanding");
          mismatch_count++;
        end else begin
          want = status_due.pop_front();
          check_field("step_level", want.level, step_level);
          check_field("step_motor", want.motor, step_motor);
          check_field("busy_res", want.busy, busy_res);
          check_field("move_done", want.done, move_done);
          check_field("start_rejected", want.rejected, start_rejected);
        end
      end
    end
  end

  // Watchdog: every request is answered, so a long quiet stretch means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RAMP_LEN_0, CFG_RAMP_LEN_1, CFG_RAMP_LEN_2, CFG_RAMP_LEN_3:
        ramp_len_q[idx[1:0]] = val[9:0];
      CFG_FIXED_DELAY:  fixed_delay_q = val;
      CFG_SYSTEM_READY: ready_q = val[0];
      CFG_DEBUG_MODE:   debug_q = val[0];
      default: ;
    endcase
  endtask

  // Wait until every queued request is sent and answered, then let the pipe empty.
  task automatic settle();
    do @(negedge clk); while (request_backlog.size() != 0 || in_valid || status_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int counted;
    for (int i = 0; i < 4; i++) ramp_len_q[i] = 10'd0;
    fixed_delay_q = FIXED_DELAY_RESET;
    ready_q = 1'b0;
    debug_q = 1'b0;
    for (int c = 0; c < 2; c++) begin
      st[c] = '0;
      st[c].ph = PH_IDLE;
      for (int i = 0; i < PROFILE_COUNT * DEPTH; i++) delay_mem[c][i] = '0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: load the first table entries and poke the idle block.
    @(negedge clk);
    for (int p = 0; p < PROFILE_COUNT; p++)
      for (int i = 0; i < 8; i++) add_write(2'(p), 9'(i), 16'($urandom_range(3, 1)));
    add_write(2'd3, 9'd511, 16'hFFFF);  // widest value at the top index, then shorten it
    add_write(2'd3, 9'd511, 16'd1);
    queue_req(blank_req(OP_NOP));
    queue_req(blank_req(OP_TICK));      // tick with nothing running
    add_start(1'b0, 1'b0, 1'b0, 16'd0); // zero pulse count: stays idle
    settle();

    // Still not ready, so the move takes the fallback profile; a short
    // half-period keeps it brief.
    write_reg(CFG_FIXED_DELAY, 16'd2);
    @(negedge clk);
    add_start(1'b1, 1'b1, 1'b1, 16'd1);
    add_start(1'b0, 1'b1, 1'b0, 16'hFFFF);  // start while busy is rejected
    add_write(2'd0, 9'd7, 16'd2);           // write during a move
    queue_req(blank_req(OP_NOP));
    finish_move();
    settle();

    // Ramp settings, zero fixed delay (stretched to one tick).
    write_reg(CFG_RAMP_LEN_0, 16'd1);
    write_reg(CFG_RAMP_LEN_1, 16'd2);
    write_reg(CFG_RAMP_LEN_2, 16'd3);
    write_reg(CFG_RAMP_LEN_3, 16'd512);
    write_reg(CFG_FIXED_DELAY, 16'd0);
    write_reg(CFG_SYSTEM_READY, 16'd1);
    write_reg(CFG_DEBUG_MODE, 16'd0);
    @(negedge clk);
    add_start(1'b0, 1'b0, 1'b1, 16'd2);   // left, loose: profile 0, exactly twice the ramp
    finish_move();
    add_start(1'b1, 1'b0, 1'b1, 16'd3);   // right grip only: profile 1, too short to ramp
    finish_move();
    add_start(1'b0, 1'b1, 1'b1, 16'd10);  // both grips: profile 2, ramp with cruise
    queue_req(blank_req(OP_TICK));
    add_write(2'd2, 9'd0, 16'd3);         // entry is read again on the way down
    finish_move();
    add_start(1'b1, 1'b1, 1'b0, 16'd4);   // right side, left grip only: profile 0
    finish_move();
    settle();

    // Debug mode forces fixed delay even when a ramp would fit.
    write_reg(CFG_DEBUG_MODE, 16'd1);
    @(negedge clk);
    add_start(1'b0, 1'b1, 1'b1, 16'd10);
    finish_move();
    settle();

    // Zero ramp length falls back to fixed delay.
    write_reg(CFG_DEBUG_MODE, 16'd0);
    write_reg(CFG_RAMP_LEN_1, 16'd0);
    write_reg(CFG_FIXED_DELAY, 16'd2);
    @(negedge clk);
    add_start(1'b0, 1'b1, 1'b0, 16'd5);
    finish_move();
    settle();

    // Random phases: new settings and a new idling pattern each time; ramp
    // lengths stay within the entries loaded so far.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      idle_mode = idle_mode_t'(k % 4);
      for (int p = 0; p < 4; p++)
        write_reg(CFG_RAMP_LEN_0 + 3'(p), 16'($urandom_range(8)));
      write_reg(CFG_FIXED_DELAY, 16'($urandom_range(3, 1)));
      write_reg(CFG_SYSTEM_READY, 16'($urandom_range(9) != 0));
      write_reg(CFG_DEBUG_MODE, 16'($urandom_range(5) == 0));
      @(negedge clk);
      counted = 0;
      while (counted < PHASE_REQS)
        counted += add_random_req(counted == PHASE_REQS / 2);
      finish_move();
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
